FILE: rtl/polynomial_evaluator_top_macros.svh
// Assertion macros for the polynomial evaluator RTL.
// Included by the modules that carry concurrent assertions; define ASSERT_OFF to drop them.
`ifndef POLYNOMIAL_EVALUATOR_TOP_MACROS_SVH
`define POLYNOMIAL_EVALUATOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every rising edge outside reset.
`define PE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Expression must never be true outside reset.
`define PE_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed");
`else
`define PE_ASSERT(lbl, clk, rst_n, prop)
`define PE_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

FILE: rtl/pe_pkg.sv
// Shared types and constants for the polynomial evaluator.
// No dependencies; imported by every module of the block except pe_ram.
package pe_pkg;

  localparam int NUM_COEFS = 10;
  localparam int IDX_W     = $clog2(NUM_COEFS);
  localparam int COEF_W    = 16;
  localparam int POINT_W   = 16;
  localparam int RES_W     = 64;
  localparam int CMD_W     = 3;
  localparam int MODE_W    = 2;
  localparam int IN_DATA_W = 40;

  localparam logic [1:0] FIN_LAST = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A = 3'd0,
    CMD_LOAD_B = 3'd1,
    CMD_SUM    = 3'd2,
    CMD_DIFF   = 3'd3,
    CMD_PROD   = 3'd4,
    CMD_DERIV  = 3'd5
  } cmd_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_SUM   = 2'd0,
    MODE_DIFF  = 2'd1,
    MODE_PROD  = 2'd2,
    MODE_DERIV = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN,
    ST_DONE
  } state_e;

  // Sequencer to datapath controls
  typedef struct packed {
    logic             start;
    logic             rd_en;
    logic             mul_en;
    logic             acc_en;
    logic             save_a;
    logic             sel_b;
    logic             fin_en;
    logic [1:0]       fin_step;
    logic [IDX_W-1:0] idx;
    logic             out_load;
  } ctl_t;

endpackage

FILE: rtl/pe_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; used for the two coefficient stores.
module pe_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pe_seq.sv
// Evaluation sequencer: walks the coefficient index, steps the Horner phases
// and the final product partials. Depends on pe_pkg and the assertion macros.
`include "polynomial_evaluator_top_macros.svh"

module pe_seq import pe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_accept_i,
  input  cmd_e in_cmd_i,
  input  logic out_free_i,
  output logic busy_o,
  output ctl_t ctl_o
);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             ph_q, ph_d;
  logic             pass_q, pass_d;
  logic [1:0]       fstep_q, fstep_d;
  cmd_e             cmd_q, cmd_d;

  logic             is_eval;
  logic             last_step;
  logic [IDX_W-1:0] last_idx;

  assign is_eval   = in_cmd_i inside {CMD_SUM, CMD_DIFF, CMD_PROD, CMD_DERIV};
  // derivative skips the constant term
  assign last_idx  = (cmd_q == CMD_DERIV) ? IDX_W'(1) : '0;
  assign last_step = (idx_q == last_idx);

  // next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    ph_d    = ph_q;
    pass_d  = pass_q;
    fstep_d = fstep_q;
    cmd_d   = cmd_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept_i && is_eval) begin
          state_d = ST_RUN;
          idx_d   = IDX_W'(NUM_COEFS - 1);
          ph_d    = 1'b0;
          pass_d  = 1'b0;
          cmd_d   = in_cmd_i;
        end
      end
      ST_RUN: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          if (!last_step) begin
            idx_d = idx_q - IDX_W'(1);
          end else if (cmd_q == CMD_PROD && !pass_q) begin
            pass_d = 1'b1;
            idx_d  = IDX_W'(NUM_COEFS - 1);
          end else if (cmd_q == CMD_PROD) begin
            state_d = ST_FIN;
            fstep_d = '0;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_FIN: begin
        fstep_d = fstep_q + 2'd1;
        if (fstep_q == FIN_LAST) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl_o          = '0;
    ctl_o.idx      = idx_q;
    ctl_o.sel_b    = pass_q;
    ctl_o.fin_step = fstep_q;
    busy_o         = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o      = 1'b0;
        ctl_o.start = in_accept_i && is_eval;
      end
      ST_RUN: begin
        ctl_o.rd_en  = !ph_q;
        ctl_o.mul_en = !ph_q;
        ctl_o.acc_en = ph_q;
        ctl_o.save_a = ph_q && last_step && (cmd_q == CMD_PROD) && !pass_q;
      end
      ST_FIN: begin
        ctl_o.fin_en = 1'b1;
      end
      ST_DONE: begin
        ctl_o.out_load = out_free_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      ph_q    <= 1'b0;
      pass_q  <= 1'b0;
      fstep_q <= '0;
      cmd_q   <= CMD_LOAD_A;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      ph_q    <= ph_d;
      pass_q  <= pass_d;
      fstep_q <= fstep_d;
      cmd_q   <= cmd_d;
    end
  end

  `PE_ASSERT(a_run_phase, clk_i, rst_ni, (state_q == ST_RUN && !ph_q) |=> (state_q == ST_RUN && ph_q))
  `PE_ASSERT(a_fin_exit, clk_i, rst_ni, (state_q == ST_FIN && fstep_q == FIN_LAST) |=> (state_q == ST_DONE))
  `PE_ASSERT_NEVER(a_idx_range, clk_i, rst_ni, (state_q == ST_RUN) && (32'(idx_q) > NUM_COEFS - 1))
  `PE_ASSERT_NEVER(a_pass_prod, clk_i, rst_ni, (state_q == ST_RUN) && pass_q && (cmd_q != CMD_PROD))

endmodule

FILE: rtl/pe_dp.sv
// Horner datapath: split 64x16 multiply, coefficient term, accumulator and
// final 64-bit product partials. Depends on pe_pkg.
module pe_dp import pe_pkg::*; (
  input  logic                      clk_i,
  input  ctl_t                      ctl_i,
  input  cmd_e                      cmd_i,
  input  logic signed [POINT_W-1:0] point_i,
  input  logic signed [COEF_W-1:0]  coef_a_i,
  input  logic signed [COEF_W-1:0]  coef_b_i,
  output logic        [RES_W-1:0]   result_value_o,
  output mode_e                     result_mode_o
);

  cmd_e                      cmd_q;
  logic signed [POINT_W-1:0] x_q;
  logic        [RES_W-1:0]   acc_q;
  logic        [RES_W-1:0]   pa_q;
  logic        [RES_W-1:0]   prod_q;
  logic signed [48:0]        mlo_q;
  logic        [31:0]        mhi_q;

  logic signed [48:0]        mlo;
  logic        [31:0]        mhi;
  logic        [31:0]        x32;
  logic signed [IDX_W+16:0]  dterm;
  logic        [RES_W-1:0]   a_ext, b_ext, term, acc_sum;
  logic        [31:0]        fa, fb;
  logic        [63:0]        fmul;

  // acc * x mod 2^64 = lo32(acc)*x + (hi32(acc)*x mod 2^32) << 32
  assign x32 = {{16{x_q[POINT_W-1]}}, x_q};
  assign mlo = $signed({1'b0, acc_q[31:0]}) * x_q;
  assign mhi = acc_q[63:32] * x32;

  assign a_ext = {{(RES_W-COEF_W){coef_a_i[COEF_W-1]}}, coef_a_i};
  assign b_ext = {{(RES_W-COEF_W){coef_b_i[COEF_W-1]}}, coef_b_i};
  assign dterm = $signed({1'b0, ctl_i.idx}) * coef_a_i;

  always_comb begin
    case (cmd_q)
      CMD_SUM:   term = a_ext + b_ext;
      CMD_DIFF:  term = a_ext - b_ext;
      CMD_PROD:  term = ctl_i.sel_b ? b_ext : a_ext;
      CMD_DERIV: term = {{(RES_W-IDX_W-17){dterm[IDX_W+16]}}, dterm};
      default:   term = '0;
    endcase
  end

  assign acc_sum = {{15{mlo_q[48]}}, mlo_q} + {mhi_q, 32'b0} + term;

  // 64x64 mod 2^64 from three 32x32 partials
  always_comb begin
    case (ctl_i.fin_step)
      2'd0:    begin fa = pa_q[31:0];  fb = acc_q[31:0];  end
      2'd1:    begin fa = pa_q[31:0];  fb = acc_q[63:32]; end
      default: begin fa = pa_q[63:32]; fb = acc_q[31:0];  end
    endcase
  end

  assign fmul = fa * fb;

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      cmd_q <= cmd_i;
      x_q   <= point_i;
      acc_q <= '0;
    end else if (ctl_i.acc_en) begin
      if (ctl_i.save_a) begin
        pa_q  <= acc_sum;
        acc_q <= '0;
      end else begin
        acc_q <= acc_sum;
      end
    end
    if (ctl_i.mul_en) begin
      mlo_q <= mlo;
      mhi_q <= mhi;
    end
    if (ctl_i.fin_en) begin
      if (ctl_i.fin_step == 2'd0) begin
        prod_q <= fmul;
      end else begin
        prod_q <= {prod_q[63:32] + fmul[31:0], prod_q[31:0]};
      end
    end
  end

  assign result_value_o = (cmd_q == CMD_PROD) ? prod_q : acc_q;

  always_comb begin
    case (cmd_q)
      CMD_SUM:  result_mode_o = MODE_SUM;
      CMD_DIFF: result_mode_o = MODE_DIFF;
      CMD_PROD: result_mode_o = MODE_PROD;
      default:  result_mode_o = MODE_DERIV;
    endcase
  end

endmodule

FILE: rtl/polynomial_evaluator_top.sv
// Polynomial evaluator over coefficient stores A and B (Horner, wraps mod 2^64).
// Loads: one per cycle while no evaluation is in progress. Each Horner step reads the
// RAM and registers the split multiply, then accumulates. Input is held off until the
// result is registered, so one evaluation must finish before the next is accepted.
// Coefficient RAMs are not reset; rst_ni (async, active low) clears the sequencer and out valid.
`include "polynomial_evaluator_top_macros.svh"

module polynomial_evaluator_top import pe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // [3:0] coef_index, [19:4] coef_value, [35:20] eval_point, [39:36] zero
  input  logic [IN_DATA_W-1:0] s_axis_tdata_i,
  // [2:0] cmd
  input  logic [CMD_W-1:0]     s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [63:0] result_value
  output logic [RES_W-1:0]     m_axis_tdata_o,
  // [1:0] result_mode
  output logic [MODE_W-1:0]    m_axis_tuser_o
);

  logic                      in_accept;
  cmd_e                      in_cmd;
  logic [3:0]                in_index;
  logic [COEF_W-1:0]         in_value;
  logic signed [POINT_W-1:0] in_point;
  logic                      load_ok;
  logic                      we_a, we_b;
  logic                      busy;
  logic                      out_free;
  ctl_t                      ctl;
  logic [COEF_W-1:0]         rd_a, rd_b;
  logic [RES_W-1:0]          dp_value;
  mode_e                     dp_mode;

  logic                      out_valid_q, out_valid_d;
  logic [RES_W-1:0]          out_data_q;
  mode_e                     out_mode_q;

  assign in_cmd   = cmd_e'(s_axis_tuser_i);
  assign in_index = s_axis_tdata_i[3:0];
  assign in_value = s_axis_tdata_i[19:4];
  assign in_point = $signed(s_axis_tdata_i[35:20]);

  assign s_axis_tready_o = !busy;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  assign load_ok = 32'(in_index) < NUM_COEFS;
  assign we_a    = in_accept && (in_cmd == CMD_LOAD_A) && load_ok;
  assign we_b    = in_accept && (in_cmd == CMD_LOAD_B) && load_ok;

  pe_ram #(.DEPTH(NUM_COEFS), .WIDTH(COEF_W)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (IDX_W'(in_index)),
    .wdata_i (in_value),
    .re_i    (ctl.rd_en),
    .raddr_i (ctl.idx),
    .rdata_o (rd_a)
  );

  pe_ram #(.DEPTH(NUM_COEFS), .WIDTH(COEF_W)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (IDX_W'(in_index)),
    .wdata_i (in_value),
    .re_i    (ctl.rd_en),
    .raddr_i (ctl.idx),
    .rdata_o (rd_b)
  );

  assign out_free = !out_valid_q || m_axis_tready_i;

  pe_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .in_cmd_i    (in_cmd),
    .out_free_i  (out_free),
    .busy_o      (busy),
    .ctl_o       (ctl)
  );

  pe_dp u_dp (
    .clk_i          (clk_i),
    .ctl_i          (ctl),
    .cmd_i          (in_cmd),
    .point_i        (in_point),
    .coef_a_i       ($signed(rd_a)),
    .coef_b_i       ($signed(rd_b)),
    .result_value_o (dp_value),
    .result_mode_o  (dp_mode)
  );

  // output register decouples the result from the next evaluation
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.out_load) begin
      out_data_q <= dp_value;
      out_mode_q <= dp_mode;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_mode_q;

  `PE_ASSERT(a_out_slot, clk_i, rst_ni, ctl.out_load |-> (!out_valid_q || m_axis_tready_i))

endmodule

FILE: sim/polynomial_evaluator_top_tb.sv
// Self-checking testbench for polynomial_evaluator_top: stream stimulus, Horner predictor.
// Depends on pe_pkg and the block's RTL only.
`timescale 1ns / 100ps

module polynomial_evaluator_top_tb;
  import pe_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;
  localparam int IDX_MAX        = (1 << IDX_W) - 1;
  localparam int PAD_W          = IN_DATA_W - IDX_W - COEF_W - POINT_W;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int STALL_LIMIT    = 4000;
  localparam int SETTLE_CYCLES  = 4 * NUM_COEFS + 8;
  localparam int PHASE_ITEMS    = 420;

  typedef enum int {POLY_A, POLY_B, POLY_SUM, POLY_DIFF} poly_sel_e;

  class poly_eval_scoreboard;
    logic [COEF_W-1:0] coef_a [NUM_COEFS];
    logic [COEF_W-1:0] coef_b [NUM_COEFS];
    logic [RES_W-1:0]  pending_value_q [$];
    mode_e             pending_mode_q [$];
    int unsigned       err_cnt;

    function new();
      foreach (coef_a[i]) begin
        coef_a[i] = '0;
        coef_b[i] = '0;
      end
      err_cnt = 0;
    endfunction

    function logic [RES_W-1:0] widen(logic [COEF_W-1:0] c);
      return {{(RES_W-COEF_W){c[COEF_W-1]}}, c};
    endfunction

    function logic [RES_W-1:0] horner_eval(poly_sel_e sel, logic [RES_W-1:0] x);
      logic [RES_W-1:0] acc;
      logic [RES_W-1:0] term;
      acc = '0;
      for (int i = NUM_COEFS - 1; i >= 0; i--) begin
        case (sel)
          POLY_A:   term = widen(coef_a[i]);
          POLY_B:   term = widen(coef_b[i]);
          POLY_SUM: term = widen(coef_a[i]) + widen(coef_b[i]);
          default:  term = widen(coef_a[i]) - widen(coef_b[i]);
        endcase
        acc = acc * x + term;
      end
      return acc;
    endfunction

    // constant term skipped, so x = 0 yields the x^1 coefficient
    function logic [RES_W-1:0] horner_deriv(logic [RES_W-1:0] x);
      logic [RES_W-1:0] acc;
      acc = '0;
      for (int i = NUM_COEFS - 1; i >= 1; i--)
        acc = acc * x + RES_W'(i) * widen(coef_a[i]);
      return acc;
    endfunction

    function void expect_result(logic [RES_W-1:0] value, mode_e mode);
      pending_value_q.push_back(value);
      pending_mode_q.push_back(mode);
    endfunction

    function void accept_command(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                 logic [COEF_W-1:0] val, logic [POINT_W-1:0] x);
      logic [RES_W-1:0] xw;
      xw = {{(RES_W-POINT_W){x[POINT_W-1]}}, x};
      case (cmd)
        CMD_LOAD_A: if (idx < NUM_COEFS) coef_a[idx] = val;
        CMD_LOAD_B: if (idx < NUM_COEFS) coef_b[idx] = val;
        CMD_SUM:    expect_result(horner_eval(POLY_SUM, xw), MODE_SUM);
        CMD_DIFF:   expect_result(horner_eval(POLY_DIFF, xw), MODE_DIFF);
        CMD_PROD:   expect_result(horner_eval(POLY_A, xw) * horner_eval(POLY_B, xw), MODE_PROD);
        CMD_DERIV:  expect_result(horner_deriv(xw), MODE_DERIV);
        default: ;
      endcase
    endfunction

    function void check_result(logic [RES_W-1:0] value, logic [MODE_W-1:0] mode);
      logic [RES_W-1:0] exp_value;
      mode_e            exp_mode;
      if (pending_value_q.size() == 0) begin
        $error("unexpected result transaction: result_value %0d, result_mode %0d",
               $signed(value), mode);
        err_cnt++;
        return;
      end
      exp_value = pending_value_q.pop_front();
      exp_mode  = pending_mode_q.pop_front();
      if (value !== exp_value) begin
        $error("result_value: expected %0d, actual %0d", $signed(exp_value), $signed(value));
        err_cnt++;
      end
      if (mode !== exp_mode) begin
        $error("result_mode: expected %0d, actual %0d", exp_mode, mode);
        err_cnt++;
      end
    endfunction

    function int pending();
      return pending_value_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [CMD_W-1:0]     s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [RES_W-1:0]     m_tdata;
  logic [MODE_W-1:0]    m_tuser;

  poly_eval_scoreboard sb;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  bit          hold_req     = 1'b0;
  int          hold_left    = 0;
  int          quiet_cycles = 0;

  polynomial_evaluator_top u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = RX_HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready)
      sb.check_result(m_tdata, m_tuser);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [15:0] pick_value();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3, 4: return 16'($urandom_range(6) - 3);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                           input logic [COEF_W-1:0] val, input logic [POINT_W-1:0] x);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {{PAD_W{1'b0}}, x, val, idx};
    do @(posedge clk); while (!s_tready);
    sb.accept_command(cmd, idx, val, x);
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {{PAD_W{1'b0}}, 32'($urandom), 4'($urandom)};
      s_tuser  <= CMD_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_item();
    int unsigned      pick;
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    pick = $urandom_range(99);
    idx  = IDX_W'($urandom_range(NUM_COEFS - 1));
    if (pick < 30) begin
      cmd = CMD_W'($urandom_range(CMD_LOAD_B, CMD_LOAD_A));
      if ($urandom_range(19) == 0) idx = IDX_W'($urandom_range(IDX_MAX, NUM_COEFS));
    end else if (pick < 96) begin
      cmd = CMD_W'($urandom_range(CMD_DERIV, CMD_SUM));
    end else begin
      cmd = CMD_W'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
    end
    send_item(cmd, idx, pick_value(), pick_value());
  endtask

  // Sender pause: lower valid and wait for every outstanding result
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (PHASE_ITEMS) send_random_item();
    wait_drained();
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill both stores before any evaluation; extremes at both ends
    for (int i = 0; i < NUM_COEFS; i++)
      send_item(CMD_LOAD_A, IDX_W'(i),
                (i == 0) ? 16'h8000 : (i == NUM_COEFS - 1) ? 16'h7FFF : pick_value(),
                pick_value());
    for (int i = 0; i < NUM_COEFS; i++)
      send_item(CMD_LOAD_B, IDX_W'(i),
                (i == 0) ? 16'h7FFF : (i == NUM_COEFS - 1) ? 16'h8000 : pick_value(),
                pick_value());
    send_item(CMD_LOAD_A, IDX_W'(IDX_MAX), 16'h1234, 16'h0);  // out of range, ignored
    send_item(CMD_SUM,   '0, '0, 16'h0000);
    send_item(CMD_DIFF,  '0, '0, 16'h7FFF);
    send_item(CMD_PROD,  '0, '0, 16'h8000);
    send_item(CMD_DERIV, '0, '0, 16'h0000);
    send_item(CMD_DERIV, '0, '0, 16'hFFFF);
    send_item(CMD_PROD,  '0, '0, 16'h0001);
    send_item(CMD_RSVD_LO, IDX_W'(IDX_MAX), 16'hFFFF, 16'hFFFF);
    send_item(CMD_RSVD_HI, '0, '0, '0);
    wait_drained();

    run_phase(0, 0);
    run_phase(58, 0);
    run_phase(0, 58);
    run_phase(20, 20);

    // Receiver held off while the sender keeps pushing evaluations
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_req     = 1'b1;
    repeat (40) send_item(CMD_PROD, '0, '0, pick_value());
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.err_cnt == 0 && sb.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: polynomial_evaluator_top.f
+incdir+rtl
rtl/pe_pkg.sv
rtl/pe_ram.sv
rtl/pe_seq.sv
rtl/pe_dp.sv
rtl/polynomial_evaluator_top.sv
sim/polynomial_evaluator_top_tb.sv
